### src/vmt_pkg.sv
package vmt_pkg;

  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int PAIR_W    = PROD_W + 1;
  localparam int SUM_W     = PROD_W + 2;
  localparam int MAT_DIM   = 4;
  localparam int MAT_SIZE  = MAT_DIM * MAT_DIM;
  localparam int IDX_W     = 4;
  localparam int REQ_W     = 2;
  localparam int FRAC_BITS_DEFAULT = 16;

  // request kinds carried in tuser
  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_IDENT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_XFORM = 2'd2;

  localparam logic [DATA_W-1:0] ELEM_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] ELEM_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef logic [MAT_SIZE-1:0][DATA_W-1:0]   mat_t;
  typedef logic [MAT_DIM-1:0][DATA_W-1:0]    vec_t;
  typedef logic [MAT_SIZE-1:0][PROD_W-1:0]   prod_arr_t;
  typedef logic [2*MAT_DIM-1:0][PAIR_W-1:0]  pair_arr_t;

  typedef struct packed {
    logic              load;
    logic              ident;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] value;
  } mat_cmd_t;

endpackage

### src/vmt_matrix.sv
module vmt_matrix #(
  parameter int FRAC_BITS = vmt_pkg::FRAC_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  vmt_pkg::mat_cmd_t cmd,
  output vmt_pkg::mat_t    mat
);

  localparam int DIM_SH = $clog2(vmt_pkg::MAT_DIM);

  localparam logic [vmt_pkg::DATA_W-1:0] ONE =
    {{(vmt_pkg::DATA_W-1){1'b0}}, 1'b1} << FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst || cmd.ident) begin
      // diagonal: column equals row
      for (int k = 0; k < vmt_pkg::MAT_SIZE; k++) begin
        mat[k] <= ((k >> DIM_SH) == (k & (vmt_pkg::MAT_DIM - 1))) ? ONE : '0;
      end
    end else if (cmd.load) begin
      mat[cmd.idx] <= cmd.value;
    end
  end

endmodule

### src/vmt_mul_stage.sv
module vmt_mul_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  vmt_pkg::vec_t        vec,
  input  vmt_pkg::mat_t        mat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output vmt_pkg::prod_arr_t   prod
);

  localparam int DIM_SH = $clog2(vmt_pkg::MAT_DIM);

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // prod index matches matrix index: column j, row i at j*4+i, times vec[j]
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      for (int k = 0; k < vmt_pkg::MAT_SIZE; k++) begin
        prod[k] <= $signed(mat[k]) * $signed(vec[k >> DIM_SH]);
      end
    end
  end

endmodule

### src/vmt_add_stage.sv
module vmt_add_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  vmt_pkg::prod_arr_t   prod,
  output logic                 out_valid,
  input  logic                 out_ready,
  output vmt_pkg::pair_arr_t   pair
);

  localparam int D = vmt_pkg::MAT_DIM;

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // pair[2*i+h] = sum of the prods of columns 2h and 2h+1 for row i
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      for (int i = 0; i < D; i++) begin
        for (int h = 0; h < 2; h++) begin
          pair[2*i+h] <=
            $signed({prod[(2*h)*D+i][vmt_pkg::PROD_W-1], prod[(2*h)*D+i]}) +
            $signed({prod[(2*h+1)*D+i][vmt_pkg::PROD_W-1], prod[(2*h+1)*D+i]});
        end
      end
    end
  end

endmodule

### src/vmt_sat_stage.sv
module vmt_sat_stage #(
  parameter int FRAC_BITS = vmt_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  vmt_pkg::pair_arr_t   pair,
  output logic                 out_valid,
  input  logic                 out_ready,
  output vmt_pkg::vec_t        res,
  output logic                 sat
);

  localparam int D  = vmt_pkg::MAT_DIM;
  localparam int SW = vmt_pkg::SUM_W;
  localparam int DW = vmt_pkg::DATA_W;

  logic signed [SW-1:0] total   [D];
  logic signed [SW-1:0] shifted [D];
  logic [D-1:0]         fits;
  vmt_pkg::vec_t        clipped;

  always_comb begin
    for (int i = 0; i < D; i++) begin
      total[i] = $signed({pair[2*i][vmt_pkg::PAIR_W-1], pair[2*i]}) +
                 $signed({pair[2*i+1][vmt_pkg::PAIR_W-1], pair[2*i+1]});
      // arithmetic shift is the floor of the division
      shifted[i] = total[i] >>> FRAC_BITS;
      fits[i] = (&shifted[i][SW-1:DW-1]) || !(|shifted[i][SW-1:DW-1]);
      if (fits[i]) begin
        clipped[i] = shifted[i][DW-1:0];
      end else if (shifted[i][SW-1]) begin
        clipped[i] = vmt_pkg::ELEM_MIN;
      end else begin
        clipped[i] = vmt_pkg::ELEM_MAX;
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      res <= clipped;
      sat <= !(&fits);
    end
  end

endmodule

### src/vertex_matrix_transform.sv
// Vertex transform by a stored 4x4 Q-format matrix, three register stages:
// multiply, pairwise add, final add with shift and saturation.
// Each transform word passes the multiply, add and saturation registers in order.
// Throughput: one word per cycle unless m_axis stalls; matrix loads take effect for the next word.
// Reset (rst, synchronous): matrix goes to identity, pipeline is emptied.
module vertex_matrix_transform #(
  parameter int FRAC_BITS = vmt_pkg::FRAC_BITS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // entry_index, entry_value, vec_x, vec_y, vec_z, vec_w, 4 bits zero pad
  input  logic [167:0]  s_axis_tdata,
  // req_type
  input  logic [1:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // out_x, out_y, out_z, out_w
  output logic [127:0]  m_axis_tdata,
  // saturated
  output logic [0:0]    m_axis_tuser
);

  localparam int DW    = vmt_pkg::DATA_W;
  localparam int IW    = vmt_pkg::IDX_W;
  localparam int VEC_O = IW + DW;

  logic                 accept;
  logic [vmt_pkg::REQ_W-1:0] req;
  vmt_pkg::mat_cmd_t    cmd;
  vmt_pkg::mat_t        mat;
  vmt_pkg::vec_t        vec;
  vmt_pkg::prod_arr_t   prod;
  vmt_pkg::pair_arr_t   pair;
  vmt_pkg::vec_t        res;
  logic                 mul_valid, add_ready;
  logic                 add_valid, sat_ready;
  logic                 sat;

  assign req    = s_axis_tuser;
  assign accept = s_axis_tvalid && s_axis_tready;

  assign cmd.load  = accept && (req == vmt_pkg::REQ_LOAD);
  assign cmd.ident = accept && (req == vmt_pkg::REQ_IDENT);
  assign cmd.idx   = s_axis_tdata[IW-1:0];
  assign cmd.value = s_axis_tdata[IW+DW-1:IW];

  always_comb begin
    for (int j = 0; j < vmt_pkg::MAT_DIM; j++) begin
      vec[j] = s_axis_tdata[VEC_O + j*DW +: DW];
    end
  end

  vmt_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .mat (mat)
  );

  vmt_mul_stage u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid && (req == vmt_pkg::REQ_XFORM)),
    .in_ready  (s_axis_tready),
    .vec       (vec),
    .mat       (mat),
    .out_valid (mul_valid),
    .out_ready (add_ready),
    .prod      (prod)
  );

  vmt_add_stage u_add (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mul_valid),
    .in_ready  (add_ready),
    .prod      (prod),
    .out_valid (add_valid),
    .out_ready (sat_ready),
    .pair      (pair)
  );

  vmt_sat_stage #(.FRAC_BITS(FRAC_BITS)) u_sat (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (add_valid),
    .in_ready  (sat_ready),
    .pair      (pair),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .res       (res),
    .sat       (sat)
  );

  assign m_axis_tdata = res;
  assign m_axis_tuser = sat;

  a_ident_loads: assert property (@(posedge clk) disable iff (rst)
    cmd.ident |=> (mat[0] == ({{(DW-1){1'b0}}, 1'b1} << FRAC_BITS)) && (mat[1] == '0))
    else $error("identity load did not reach matrix");

  a_entry_loads: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (mat[$past(cmd.idx)] == $past(cmd.value)))
    else $error("entry load lost");

  a_xform_enters: assert property (@(posedge clk) disable iff (rst)
    (accept && (req == vmt_pkg::REQ_XFORM)) |=> mul_valid)
    else $error("accepted transform missing from multiply stage");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (mul_valid && add_valid && m_axis_tvalid && !m_axis_tready))
    else $error("input stalled with a free pipeline slot");

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
  import vmt_pkg::*;

  localparam int FRAC = FRAC_BITS_DEFAULT;
  localparam logic [DATA_W-1:0] Q_ONE = 1 << FRAC;
  localparam logic [DATA_W-1:0] Q_HALF = 1 << (FRAC - 1);
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(2147483647);
  localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_MAX - 1;
  localparam int HOLD_CYCLES = 200;
  localparam int RANDOM_ITEMS = 1490;
  localparam int SEGMENT = 150;
  localparam int SETTLE_CYCLES = 10;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    vec_t elem;
    logic sat;
  } vertex_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  // entry_index, entry_value, vec_x, vec_y, vec_z, vec_w, 4 bits zero pad
  logic [167:0]  s_axis_tdata = '0;
  // req_type
  logic [1:0]    s_axis_tuser = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  // out_x, out_y, out_z, out_w
  logic [127:0]  m_axis_tdata;
  // saturated
  logic [0:0]    m_axis_tuser;

  // shadow of the block's matrix, column-major
  logic signed [DATA_W-1:0] mat_shadow [MAT_SIZE];
  vertex_t vertex_q [$];

  bit tx_idle_en = 1'b0;
  bit rx_idle_en = 1'b0;
  int hold_reqs = 0;
  int hold_done = 0;
  int rx_wait = 0;

  int mismatches = 0;
  int n_xform = 0, n_load = 0, n_ident = 0, n_unused = 0;
  int n_checked = 0, n_sat = 0;

  vertex_t exp_vertex;

  vertex_matrix_transform u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #10 clk = ~clk;

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(1, 3);
    if (r < 9) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DATA_W-1:0] rand_q();
    logic [DATA_W-1:0] r;
    r = $urandom;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9: return {{12{r[19]}}, r[19:0]};
      17: return ELEM_MAX;
      18: return ELEM_MIN;
      19: return ($urandom_range(0, 1) ? Q_ONE : -Q_ONE);
      default: return r;
    endcase
  endfunction

  function automatic vec_t make_vec(input logic [DATA_W-1:0] x, y, z, w);
    return {w, z, y, x};
  endfunction

  function automatic vec_t rand_vec();
    return make_vec(rand_q(), rand_q(), rand_q(), rand_q());
  endfunction

  function automatic vec_t noise_vec();
    return make_vec($urandom, $urandom, $urandom, $urandom);
  endfunction

  task automatic set_identity();
    for (int k = 0; k < MAT_SIZE; k++)
      mat_shadow[k] = (k / MAT_DIM == k % MAT_DIM) ? Q_ONE : '0;
  endtask

  // exact 66-bit dot products, floor shift, clip to 32 bits
  function automatic vertex_t transform_vertex(input vec_t vin);
    vertex_t res;
    logic signed [SUM_W-1:0] acc, m, v, shifted;
    res.sat = 1'b0;
    for (int i = 0; i < MAT_DIM; i++) begin
      acc = '0;
      for (int j = 0; j < MAT_DIM; j++) begin
        m = SUM_W'(mat_shadow[j * MAT_DIM + i]);
        v = SUM_W'($signed(vin[j]));
        acc = acc + m * v;
      end
      shifted = acc >>> FRAC;
      if (shifted > SUM_MAX) begin
        res.elem[i] = ELEM_MAX;
        res.sat = 1'b1;
      end else if (shifted < SUM_MIN) begin
        res.elem[i] = ELEM_MIN;
        res.sat = 1'b1;
      end else begin
        res.elem[i] = shifted[DATA_W-1:0];
      end
    end
    return res;
  endfunction

  task automatic accept_word(input logic [REQ_W-1:0] req, input logic [IDX_W-1:0] idx,
                             input logic [DATA_W-1:0] val, input vec_t vin);
    case (req)
      REQ_LOAD: begin
        mat_shadow[idx] = val;
        n_load++;
      end
      REQ_IDENT: begin
        set_identity();
        n_ident++;
      end
      REQ_XFORM: begin
        vertex_q.push_back(transform_vertex(vin));
        n_xform++;
      end
      default: n_unused++;
    endcase
  endtask

  task automatic send_word(input logic [REQ_W-1:0] req, input logic [IDX_W-1:0] idx,
                           input logic [DATA_W-1:0] val, input vec_t vin);
    int gap;
    gap = (tx_idle_en && $urandom_range(0, 1)) ? gap_len() : 0;
    if (gap > 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {4'b0, vin, val, idx};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    accept_word(req, idx, val, vin);
  endtask

  task automatic send_load(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    send_word(REQ_LOAD, idx, val, noise_vec());
  endtask

  task automatic send_ident();
    send_word(REQ_IDENT, IDX_W'($urandom), $urandom, noise_vec());
  endtask

  task automatic send_xform(input vec_t vin);
    send_word(REQ_XFORM, IDX_W'($urandom), $urandom, vin);
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] exp_val,
                             input logic [DATA_W-1:0] act_val);
    if (act_val !== exp_val) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_val, act_val);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (vertex_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result word with none pending, data %h", $time, m_axis_tdata);
      end else begin
        exp_vertex = vertex_q.pop_front();
        n_checked++;
        if (exp_vertex.sat) n_sat++;
        check_field("out_x", exp_vertex.elem[0], m_axis_tdata[31:0]);
        check_field("out_y", exp_vertex.elem[1], m_axis_tdata[63:32]);
        check_field("out_z", exp_vertex.elem[2], m_axis_tdata[95:64]);
        check_field("out_w", exp_vertex.elem[3], m_axis_tdata[127:96]);
        check_field("saturated", DATA_W'(exp_vertex.sat), DATA_W'(m_axis_tuser));
      end
    end
  end

  // result side: random stalls, plus long hold-offs on request
  always @(negedge clk) begin
    if (hold_done != hold_reqs) begin
      hold_done = hold_reqs;
      rx_wait = HOLD_CYCLES;
    end
    if (rx_wait > 0) begin
      m_axis_tready <= 1'b0;
      rx_wait--;
    end else begin
      m_axis_tready <= 1'b1;
      if (rx_idle_en && $urandom_range(0, 3) == 0) rx_wait = gap_len();
    end
  end

  task automatic test_identity_passthrough();
    send_xform(make_vec(ELEM_MAX, ELEM_MIN, '0, '1));
    send_xform(make_vec(Q_ONE, -Q_ONE, ELEM_MIN, ELEM_MAX));
  endtask

  task automatic test_entry_extremes();
    send_load(4'd0, ELEM_MAX);
    send_load(4'd15, ELEM_MIN);
    send_load(4'd5, '0);
    send_load(4'd10, '1);
    // positive overflow on x, negative on w
    send_xform(make_vec(ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX));
    send_xform(make_vec(ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN));
    send_ident();
    // off-diagonal entry: column 1, row 2
    send_load(4'd6, Q_HALF);
    send_xform(make_vec(3 * Q_ONE, -Q_ONE, Q_ONE, '0));
    // -0.5 must floor to -1 lsb
    send_load(4'd0, Q_HALF);
    send_xform(make_vec('1, 32'd1, '0, '0));
    send_ident();
    send_xform(make_vec(Q_HALF, -Q_HALF, 32'd7, -32'd7));
  endtask

  task automatic test_unused_code();
    send_load(4'd0, 2 * Q_ONE);
    send_word(REQ_UNUSED, 4'd0, '1, make_vec('1, '1, '1, '1));
    send_word(REQ_UNUSED, 4'hF, '0, make_vec('0, '0, '0, '0));
    send_xform(make_vec(Q_ONE, Q_ONE, Q_ONE, Q_ONE));
    send_ident();
  endtask

  task automatic test_back_pressure();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    hold_reqs++;
    repeat (40) send_xform(rand_vec());
  endtask

  task automatic test_random_stream();
    int counted;
    int pick;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if (counted % SEGMENT == 0) begin
        tx_idle_en = ($urandom_range(0, 3) != 0);
        rx_idle_en = ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_xform(rand_vec());
        counted++;
      end else if (pick < 88) begin
        send_load(IDX_W'($urandom), rand_q());
        counted++;
      end else if (pick < 93) begin
        send_ident();
        counted++;
      end else begin
        send_word(REQ_UNUSED, IDX_W'($urandom), $urandom, noise_vec());
        counted++;
      end
    end
  endtask

  initial begin
    set_identity();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_identity_passthrough();
    test_entry_extremes();
    test_unused_code();
    test_back_pressure();
    test_random_stream();

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (vertex_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (vertex_q.size() != 0) mismatches++;

    $display("checked %0d transformed vertices, %0d of them clipped", n_checked, n_sat);
    $display("matrix traffic: %0d entry loads, %0d identity loads, %0d ignored words",
             n_load, n_ident, n_unused);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
